FILE: hw/rtl/bbtm_pkg.sv
// Shared constants and types for the block buffer tag manager.
// Depends on nothing; every other file of the block refers to it by scoped names.

package bbtm_pkg;

  // Number of buffer entries and the width of an entry index.
  localparam int unsigned NUM_BUFFERS = 32;
  localparam int unsigned IDX_W       = $clog2(NUM_BUFFERS);

  // Field widths fixed by the interface.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned DEV_W   = 8;
  localparam int unsigned BLK_W   = 32;
  localparam int unsigned BI_W    = 5;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PIN     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UNPIN   = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_COUNT  = 2'd2;

  // Saturation limit of a reference count.
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

  // Tag of one entry as kept in the tag RAM.
  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [BLK_W-1:0] block;
  } tag_t;

  // Verdict of the compare unit on one entry.
  typedef struct packed {
    logic live;
    logic match;
    logic free;
  } cmp_res_t;

endpackage

FILE: hw/rtl/bbtm_tag_ram.sv
// Tag RAM of the block buffer tag manager: one device and block tag per entry.
// One write port and one read port with registered read data; uses bbtm_pkg.

module bbtm_tag_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [bbtm_pkg::IDX_W-1:0]  waddr_i,
  input  bbtm_pkg::tag_t              wdata_i,
  input  logic                        re_i,
  input  logic [bbtm_pkg::IDX_W-1:0]  raddr_i,
  output bbtm_pkg::tag_t              rdata_o
);

  bbtm_pkg::tag_t mem_q [bbtm_pkg::NUM_BUFFERS];
  bbtm_pkg::tag_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data available the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bbtm_cmp.sv
// Compare unit of the block buffer tag manager: checks one entry against the lookup key.
// Used once per cycle by the scan sequencer; uses bbtm_pkg.

module bbtm_cmp (
  input  bbtm_pkg::tag_t                 key_i,
  input  bbtm_pkg::tag_t                 entry_i,
  input  logic [bbtm_pkg::CNT_W-1:0]     count_i,
  output bbtm_pkg::cmp_res_t             res_o
);

  logic tag_eq;

  // An entry is live while its count is above zero; only live entries can match.
  assign tag_eq       = (key_i.device == entry_i.device) && (key_i.block == entry_i.block);
  assign res_o.live   = (count_i != '0);
  assign res_o.match  = res_o.live && tag_eq;
  assign res_o.free   = !res_o.live;

endmodule

FILE: hw/rtl/block_buffer_tag_manager.sv
// Top level of the block buffer tag manager: sequencer, reference counts and result register.
// Instantiates bbtm_tag_ram and bbtm_cmp; uses bbtm_pkg.

// A get walks the tag RAM one entry per cycle, through its single read port and the shared
// compare unit, stopping at the first live match; a full miss takes the lowest-indexed free
// entry. Write, release, pin, unpin and unknown commands skip the scan and go straight to
// the execute step. The block accepts one word at a time and can take the next word while
// the previous result still waits in the output register. Counts and valid bits reset to
// zero at once; tags are undefined until an entry is first allocated.

module block_buffer_tag_manager (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bbtm_pkg::CMD_W-1:0]     cmd_i,
  input  logic [bbtm_pkg::DEV_W-1:0]     device_i,
  input  logic [bbtm_pkg::BLK_W-1:0]     block_number_i,
  input  logic [bbtm_pkg::BI_W-1:0]      buffer_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bbtm_pkg::BI_W-1:0]      entry_index_o,
  output logic                           hit_o,
  output logic                           disk_read_o,
  output logic                           disk_write_o,
  output logic [bbtm_pkg::STAT_W-1:0]    status_o
);

  localparam int unsigned IDX_W = bbtm_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(bbtm_pkg::NUM_BUFFERS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  state_e state_q;

  // Latched command word.
  logic [bbtm_pkg::CMD_W-1:0]  cmd_q;
  bbtm_pkg::tag_t              key_q;
  logic [bbtm_pkg::BI_W-1:0]   bi_q;
  logic                        oor_q;
  logic [IDX_W-1:0]            idx_q;

  // Scan bookkeeping.
  logic [IDX_W-1:0]            addr_q;
  logic                        pend_q;
  logic [IDX_W-1:0]            pend_idx_q;
  logic                        free_have_q;
  logic [IDX_W-1:0]            free_idx_q;
  logic                        hit_q;

  // Reference counts and valid bits.
  logic [bbtm_pkg::CNT_W-1:0]  cnt_q [bbtm_pkg::NUM_BUFFERS];
  logic [bbtm_pkg::NUM_BUFFERS-1:0] valid_q;

  // Result register.
  logic                        out_valid_q;
  logic [bbtm_pkg::BI_W-1:0]   res_idx_q;
  logic                        res_hit_q;
  logic                        res_rd_q;
  logic                        res_wr_q;
  logic [bbtm_pkg::STAT_W-1:0] res_st_q;

  logic                        in_fire;
  logic                        ex_fire;
  logic                        ram_re;
  bbtm_pkg::tag_t              ram_rdata;
  logic [IDX_W-1:0]            cnt_ridx;
  logic [bbtm_pkg::CNT_W-1:0]  cnt_cur;
  logic                        valid_cur;
  bbtm_pkg::cmp_res_t          cmp_res;
  logic                        oor_in;

  // Execute-step results.
  logic [bbtm_pkg::BI_W-1:0]   ex_idx;
  logic                        ex_hit;
  logic                        ex_rd;
  logic                        ex_wr;
  logic [bbtm_pkg::STAT_W-1:0] ex_st;
  logic                        cnt_we;
  logic [bbtm_pkg::CNT_W-1:0]  cnt_wdata;
  logic                        val_we;
  logic                        tag_we;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ex_fire    = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign ram_re     = (state_q == ST_SCAN);
  assign oor_in     = ({{(9 - bbtm_pkg::BI_W){1'b0}}, buffer_index_i}
                       >= 9'(bbtm_pkg::NUM_BUFFERS));

  // The count array has a single read index: the entry under compare during a scan,
  // the selected entry otherwise.
  assign cnt_ridx  = (state_q == ST_SCAN) ? pend_idx_q : idx_q;
  assign cnt_cur   = cnt_q[cnt_ridx];
  assign valid_cur = valid_q[idx_q];

  bbtm_tag_ram u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (idx_q),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  bbtm_cmp u_cmp (
    .key_i   (key_q),
    .entry_i (ram_rdata),
    .count_i (cnt_cur),
    .res_o   (cmp_res)
  );

  // Execute step: count update, allocation and result fields for the latched word.
  always_comb begin
    ex_idx    = bi_q;
    ex_hit    = 1'b0;
    ex_rd     = 1'b0;
    ex_wr     = 1'b0;
    ex_st     = bbtm_pkg::ST_OK;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_cur;
    val_we    = 1'b0;
    tag_we    = 1'b0;
    if (cmd_q == bbtm_pkg::CMD_GET) begin
      if (hit_q) begin
        ex_idx = bbtm_pkg::BI_W'(idx_q);
        ex_hit = 1'b1;
        if (cnt_cur == bbtm_pkg::COUNT_MAX) begin
          ex_st = bbtm_pkg::ST_COUNT;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_cur + 1'b1;
        end
        ex_rd  = !valid_cur;
        val_we = 1'b1;
      end else if (free_have_q) begin
        // Fresh allocation: the entry takes a new tag, so it always needs a fill.
        ex_idx    = bbtm_pkg::BI_W'(idx_q);
        tag_we    = ex_fire;
        cnt_we    = 1'b1;
        cnt_wdata = bbtm_pkg::CNT_W'(1);
        ex_rd     = 1'b1;
        val_we    = 1'b1;
      end else begin
        ex_idx = '0;
        ex_st  = bbtm_pkg::ST_NOFREE;
      end
    end else if (cmd_q > bbtm_pkg::CMD_UNPIN) begin
      ex_idx = '0;
    end else if (!oor_q) begin
      case (cmd_q)
        bbtm_pkg::CMD_WRITE: begin
          ex_wr = 1'b1;
        end
        bbtm_pkg::CMD_PIN: begin
          if (cnt_cur == bbtm_pkg::COUNT_MAX) begin
            ex_st = bbtm_pkg::ST_COUNT;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_cur + 1'b1;
          end
        end
        bbtm_pkg::CMD_RELEASE, bbtm_pkg::CMD_UNPIN: begin
          if (cnt_cur == '0) begin
            ex_st = bbtm_pkg::ST_COUNT;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_cur - 1'b1;
          end
        end
        default: begin
          ex_wr = 1'b0;
        end
      endcase
    end
  end

  // Reference counts and valid bits, updated only when the execute step retires.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bbtm_pkg::NUM_BUFFERS; i++) begin
        cnt_q[i] <= '0;
      end
      valid_q <= '0;
    end else if (ex_fire) begin
      if (cnt_we) begin
        cnt_q[idx_q] <= cnt_wdata;
      end
      if (val_we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  // Sequencer: accept, scan the tag RAM, execute, hand over to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      free_have_q <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ex_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            addr_q      <= '0;
            pend_q      <= 1'b0;
            free_have_q <= 1'b0;
            hit_q       <= 1'b0;
            state_q     <= (cmd_i == bbtm_pkg::CMD_GET) ? ST_SCAN : ST_EXEC;
          end
        end
        ST_SCAN: begin
          // Issue the next read while the previous entry is compared.
          addr_q <= (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;
          if (pend_q && cmp_res.match) begin
            hit_q   <= 1'b1;
            pend_q  <= 1'b0;
            state_q <= ST_EXEC;
          end else if (pend_q && (pend_idx_q == LAST_IDX)) begin
            free_have_q <= free_have_q || cmp_res.free;
            pend_q      <= 1'b0;
            state_q     <= ST_EXEC;
          end else begin
            pend_q <= 1'b1;
            if (pend_q && cmp_res.free && !free_have_q) begin
              free_have_q <= 1'b1;
            end
          end
        end
        ST_EXEC: begin
          if (ex_fire) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q        <= cmd_i;
      key_q.device <= device_i;
      key_q.block  <= block_number_i;
      bi_q         <= buffer_index_i;
      oor_q        <= oor_in;
      idx_q        <= IDX_W'(buffer_index_i);
    end
    if (state_q == ST_SCAN) begin
      pend_idx_q <= addr_q;
      if (pend_q) begin
        if (cmp_res.match) begin
          idx_q <= pend_idx_q;
        end else if (pend_idx_q == LAST_IDX) begin
          idx_q <= free_have_q ? free_idx_q : pend_idx_q;
        end else if (cmp_res.free && !free_have_q) begin
          free_idx_q <= pend_idx_q;
        end
      end
    end
    if (ex_fire) begin
      res_idx_q <= ex_idx;
      res_hit_q <= ex_hit;
      res_rd_q  <= ex_rd;
      res_wr_q  <= ex_wr;
      res_st_q  <= ex_st;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_index_o = res_idx_q;
  assign hit_o         = res_hit_q;
  assign disk_read_o   = res_rd_q;
  assign disk_write_o  = res_wr_q;
  assign status_o      = res_st_q;

endmodule

FILE: hw/rtl/bbtm_checker.sv
// Port-level checker for the block buffer tag manager, bound to the top level.
// Uses bbtm_pkg for the status codes.

module bbtm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [bbtm_pkg::BI_W-1:0]      entry_index_o,
  input logic                           hit_o,
  input logic                           disk_read_o,
  input logic                           disk_write_o,
  input logic [bbtm_pkg::STAT_W-1:0]    status_o
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // The block works on one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new word accepted right after another");

  // A disk write request never comes with get fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && disk_write_o |-> !hit_o && !disk_read_o &&
      (status_o == bbtm_pkg::ST_OK))
    else $error("write result carries get fields");

  // A get with no free entry reports nothing but the status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == bbtm_pkg::ST_NOFREE) |->
      !hit_o && !disk_read_o && !disk_write_o && (entry_index_o == '0))
    else $error("no-free result carries other fields");

endmodule

bind block_buffer_tag_manager bbtm_checker u_bbtm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .entry_index_o (entry_index_o),
  .hit_o         (hit_o),
  .disk_read_o   (disk_read_o),
  .disk_write_o  (disk_write_o),
  .status_o      (status_o)
);

FILE: dv/bbtm_tag_checker.sv
`timescale 1ns / 100ps
// Checker for the block buffer tag manager: watches both channels and predicts every result.
// Depends on bbtm_pkg for widths, command and status codes.

module bbtm_tag_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [bbtm_pkg::CMD_W-1:0]  cmd_i,
  input  logic [bbtm_pkg::DEV_W-1:0]  device_i,
  input  logic [bbtm_pkg::BLK_W-1:0]  block_number_i,
  input  logic [bbtm_pkg::BI_W-1:0]   buffer_index_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [bbtm_pkg::BI_W-1:0]   entry_index_i,
  input  logic                        hit_i,
  input  logic                        disk_read_i,
  input  logic                        disk_write_i,
  input  logic [bbtm_pkg::STAT_W-1:0] status_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  // One result word as the block returns it.
  typedef struct packed {
    logic [bbtm_pkg::BI_W-1:0]   index;
    logic                        hit;
    logic                        disk_read;
    logic                        disk_write;
    logic [bbtm_pkg::STAT_W-1:0] status;
  } tag_result_t;

  // Shadow copy of the tag store, counts and valid bits.
  logic [bbtm_pkg::DEV_W-1:0] dev_tag   [bbtm_pkg::NUM_BUFFERS];
  logic [bbtm_pkg::BLK_W-1:0] blk_tag   [bbtm_pkg::NUM_BUFFERS];
  logic [bbtm_pkg::CNT_W-1:0] pin_count [bbtm_pkg::NUM_BUFFERS];
  logic                       data_valid[bbtm_pkg::NUM_BUFFERS];

  tag_result_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned waiting    = 0;
  int unsigned word_no    = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  // Prints one line for a bad word and counts it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Applies one accepted word to the shadow state and works out the word it must return.
  task automatic apply_word(input logic [bbtm_pkg::CMD_W-1:0] cmd,
                           input logic [bbtm_pkg::DEV_W-1:0] dev,
                           input logic [bbtm_pkg::BLK_W-1:0] blk,
                           input logic [bbtm_pkg::BI_W-1:0] bi,
                           output tag_result_t res);
    int found;
    res   = '0;
    found = -1;
    case (cmd)
      bbtm_pkg::CMD_GET: begin
        // A live entry with matching tags wins; the lowest index comes first.
        for (int i = 0; i < bbtm_pkg::NUM_BUFFERS; i++) begin
          if (found < 0 && pin_count[i] != '0 &&
              dev_tag[i] == dev && blk_tag[i] == blk) begin
            found = i;
          end
        end
        if (found >= 0) begin
          res.hit = 1'b1;
          if (pin_count[found] == bbtm_pkg::COUNT_MAX) begin
            res.status = bbtm_pkg::ST_COUNT;
          end else begin
            pin_count[found]++;
          end
        end else begin
          // Miss: claim the lowest free entry and retag it.
          for (int i = 0; i < bbtm_pkg::NUM_BUFFERS; i++) begin
            if (found < 0 && pin_count[i] == '0) begin
              found = i;
            end
          end
          if (found >= 0) begin
            dev_tag[found]    = dev;
            blk_tag[found]    = blk;
            data_valid[found] = 1'b0;
            pin_count[found]  = bbtm_pkg::CNT_W'(1);
          end
        end
        if (found < 0) begin
          res.status = bbtm_pkg::ST_NOFREE;
        end else begin
          res.index = bbtm_pkg::BI_W'(found);
          if (!data_valid[found]) begin
            res.disk_read     = 1'b1;
            data_valid[found] = 1'b1;
          end
        end
      end
      bbtm_pkg::CMD_WRITE, bbtm_pkg::CMD_RELEASE, bbtm_pkg::CMD_PIN,
      bbtm_pkg::CMD_UNPIN: begin
        res.index = bi;
        if (bi < bbtm_pkg::NUM_BUFFERS) begin
          case (cmd)
            bbtm_pkg::CMD_WRITE: begin
              res.disk_write = 1'b1;
            end
            bbtm_pkg::CMD_PIN: begin
              if (pin_count[bi] == bbtm_pkg::COUNT_MAX) begin
                res.status = bbtm_pkg::ST_COUNT;
              end else begin
                pin_count[bi]++;
              end
            end
            default: begin
              // Release and unpin both drop the count; at zero the entry is gone.
              if (pin_count[bi] == '0) begin
                res.status = bbtm_pkg::ST_COUNT;
              end else begin
                pin_count[bi]--;
              end
            end
          endcase
        end
      end
      default: begin
        // Unknown commands return an all-zero word.
      end
    endcase
  endtask

  // Sample both channels at the clock edge; results are checked before new words are queued.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    tag_result_t got;
    tag_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < bbtm_pkg::NUM_BUFFERS; i++) begin
        dev_tag[i]    = '0;
        blk_tag[i]    = '0;
        pin_count[i]  = '0;
        data_valid[i] = 1'b0;
      end
      expected_words.delete();
      waiting = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{entry_index_i, hit_i, disk_read_i, disk_write_i, status_i};
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf(
            "word %0d arrived with none expected: idx %0d hit %b rd %b wr %b st %0d",
            word_no, got.index, got.hit, got.disk_read, got.disk_write, got.status));
        end else begin
          want = expected_words.pop_front();
          // The case inequality also catches unknown bits on any field.
          if (got !== want) begin
            report_mismatch($sformatf(
              "word %0d got idx %0d hit %b rd %b wr %b st %0d, want idx %0d hit %b rd %b wr %b st %0d",
              word_no, got.index, got.hit, got.disk_read, got.disk_write, got.status,
              want.index, want.hit, want.disk_read, want.disk_write, want.status));
          end
        end
        word_no++;
      end
      if (in_valid_i && in_ready_i) begin
        apply_word(cmd_i, device_i, block_number_i, buffer_index_i, want);
        expected_words.push_back(want);
      end
      waiting = expected_words.size();
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the block buffer tag manager: clock, reset, stimulus and the verdict.
// Depends on bbtm_pkg, the block itself and bbtm_tag_checker.

module tb;

  localparam int unsigned RANDOM_WORDS = 390;
  localparam int unsigned POOL_SIZE    = 48;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned RX_HOLD_AT   = 3000;
  localparam int unsigned RX_HOLD_LEN  = 300;
  localparam int unsigned RX_CALM_FROM = 1200;
  localparam int unsigned RX_CALM_TO   = 2200;
  localparam int unsigned SETTLE       = 40;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        in_valid_i     = 1'b0;
  logic [bbtm_pkg::CMD_W-1:0]  cmd_i          = '0;
  logic [bbtm_pkg::DEV_W-1:0]  device_i       = '0;
  logic [bbtm_pkg::BLK_W-1:0]  block_number_i = '0;
  logic [bbtm_pkg::BI_W-1:0]   buffer_index_i = '0;
  logic                        out_ready_i    = 1'b0;
  logic                        in_ready_o;
  logic                        out_valid_o;
  logic [bbtm_pkg::BI_W-1:0]   entry_index_o;
  logic                        hit_o;
  logic                        disk_read_o;
  logic                        disk_write_o;
  logic [bbtm_pkg::STAT_W-1:0] status_o;
  int unsigned                 fail_count;
  int unsigned                 pending;

  // Tags the stimulus reuses so that gets hit; the first 32 are the fill tags.
  logic [bbtm_pkg::DEV_W-1:0]  pool_dev[POOL_SIZE];
  logic [bbtm_pkg::BLK_W-1:0]  pool_blk[POOL_SIZE];
  bit                          sender_calm = 1'b0;

  block_buffer_tag_manager uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .device_i      (device_i),
    .block_number_i(block_number_i),
    .buffer_index_i(buffer_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .entry_index_o (entry_index_o),
    .hit_o         (hit_o),
    .disk_read_o   (disk_read_o),
    .disk_write_o  (disk_write_o),
    .status_o      (status_o)
  );

  bbtm_tag_checker tag_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .cmd_i         (cmd_i),
    .device_i      (device_i),
    .block_number_i(block_number_i),
    .buffer_index_i(buffer_index_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .entry_index_i (entry_index_o),
    .hit_i         (hit_o),
    .disk_read_i   (disk_read_o),
    .disk_write_i  (disk_write_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(10_000_000);
    $display("FAIL block_buffer_tag_manager");
    $finish;
  end

  // Offers one word, with random idle cycles ahead of it, and returns at the accepting edge.
  task automatic offer_word(input logic [bbtm_pkg::CMD_W-1:0] cmd,
                            input logic [bbtm_pkg::DEV_W-1:0] dev,
                            input logic [bbtm_pkg::BLK_W-1:0] blk,
                            input logic [bbtm_pkg::BI_W-1:0] bi);
    while (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    device_i       <= dev;
    block_number_i <= blk;
    buffer_index_i <= bi;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Get with a random, unused buffer index.
  task automatic get_tag(input logic [bbtm_pkg::DEV_W-1:0] dev,
                         input logic [bbtm_pkg::BLK_W-1:0] blk);
    offer_word(bbtm_pkg::CMD_GET, dev, blk, bbtm_pkg::BI_W'($urandom));
  endtask

  // Index-addressed command with random, unused tag fields.
  task automatic touch(input logic [bbtm_pkg::CMD_W-1:0] cmd,
                       input logic [bbtm_pkg::BI_W-1:0] bi);
    offer_word(cmd, bbtm_pkg::DEV_W'($urandom), bbtm_pkg::BLK_W'($urandom), bi);
  endtask

  // Stops offering until every expected word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, one long hold-off and one calm stretch.
  initial begin : receiver
    int unsigned rx_cycle;
    rx_cycle = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle == RX_HOLD_AT) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_LEN) @(posedge clk_i);
      end else if (rx_cycle >= RX_CALM_FROM && rx_cycle < RX_CALM_TO) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned pick;
    int unsigned k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every entry with distinct tags, so that every entry has tags before any pin.
    for (int i = 0; i < 32; i++) begin
      pool_dev[i] = (i == 0) ? '0 : (i == 31) ? '1 : bbtm_pkg::DEV_W'($urandom_range(255));
      pool_blk[i] = (i == 0) ? '0 : (i == 31) ? '1 : {5'(i), 27'($urandom)};
      get_tag(pool_dev[i], pool_blk[i]);
    end
    for (int i = 32; i < POOL_SIZE; i++) begin
      pool_dev[i] = bbtm_pkg::DEV_W'($urandom);
      pool_blk[i] = bbtm_pkg::BLK_W'($urandom);
    end
    pool_dev[32] = '1;
    pool_blk[32] = '0;
    pool_dev[33] = '0;
    pool_blk[33] = '1;

    // Every count is above zero, so a new tag finds no free buffer.
    get_tag('0, 32'h0000_0001);
    // Plain hit on entry 0.
    get_tag(pool_dev[0], pool_blk[0]);
    // Writes at both ends of the index range.
    touch(bbtm_pkg::CMD_WRITE, 5'd31);
    touch(bbtm_pkg::CMD_WRITE, 5'd0);
    // Entry 3 drops to zero, then its old tag misses and reclaims it with a disk read.
    touch(bbtm_pkg::CMD_RELEASE, 5'd3);
    get_tag(pool_dev[3], pool_blk[3]);
    // Write to an idle entry, then underflow on release and unpin.
    touch(bbtm_pkg::CMD_RELEASE, 5'd3);
    touch(bbtm_pkg::CMD_WRITE, 5'd3);
    touch(bbtm_pkg::CMD_RELEASE, 5'd3);
    touch(bbtm_pkg::CMD_UNPIN, 5'd3);
    // Pin brings entry 3 back to life with its old tags; a get then hits without a read.
    touch(bbtm_pkg::CMD_PIN, 5'd3);
    get_tag(pool_dev[3], pool_blk[3]);
    // Unknown commands.
    offer_word(3'd5, '1, '1, '1);
    offer_word(3'd6, '0, '0, '0);
    offer_word(3'd7, '1, '0, '1);

    // Drive entry 5 to saturation, overflow by pin and by get, then unpin it away.
    for (int i = 0; i < 255; i++) touch(bbtm_pkg::CMD_PIN, 5'd5);
    get_tag(pool_dev[5], pool_blk[5]);
    for (int i = 0; i < 255; i++) touch(bbtm_pkg::CMD_UNPIN, 5'd5);
    touch(bbtm_pkg::CMD_UNPIN, 5'd5);
    get_tag(pool_dev[5], pool_blk[5]);

    // Random traffic over reused and fresh tags.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sender_calm = (n >= 150 && n < 250);
      if (n == 300) begin
        drain_results();
      end
      pick = $urandom_range(99);
      k    = $urandom_range(POOL_SIZE - 1);
      if (pick < 30) begin
        get_tag(pool_dev[k], pool_blk[k]);
      end else if (pick < 36) begin
        get_tag(bbtm_pkg::DEV_W'($urandom), bbtm_pkg::BLK_W'($urandom));
      end else if (pick < 58) begin
        touch(bbtm_pkg::CMD_RELEASE, bbtm_pkg::BI_W'($urandom));
      end else if (pick < 70) begin
        touch(bbtm_pkg::CMD_UNPIN, bbtm_pkg::BI_W'($urandom));
      end else if (pick < 80) begin
        touch(bbtm_pkg::CMD_PIN, bbtm_pkg::BI_W'($urandom));
      end else if (pick < 92) begin
        touch(bbtm_pkg::CMD_WRITE, bbtm_pkg::BI_W'($urandom));
      end else begin
        offer_word(bbtm_pkg::CMD_W'($urandom_range(7, 5)), bbtm_pkg::DEV_W'($urandom),
                   bbtm_pkg::BLK_W'($urandom), bbtm_pkg::BI_W'($urandom));
      end
    end
    sender_calm = 1'b0;

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS block_buffer_tag_manager");
    end else begin
      $display("FAIL block_buffer_tag_manager");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bbtm_pkg.sv
hw/rtl/bbtm_tag_ram.sv
hw/rtl/bbtm_cmp.sv
hw/rtl/block_buffer_tag_manager.sv
hw/rtl/bbtm_checker.sv
dv/bbtm_tag_checker.sv
dv/tb.sv
